// ----- rtl/resonant_four_pole_filter_macros.svh -----
// Assertion macros for the resonant four-pole filter.
// Included by the top level; depends on nothing else.
`ifndef RESONANT_FOUR_POLE_FILTER_MACROS_SVH
`define RESONANT_FOUR_POLE_FILTER_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define RFPF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication.
`define RFPF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ----- rtl/rfpf_pkg.sv -----
// Package for the resonant four-pole filter: widths, constants, state codes.
// Used by rfpf_div and resonant_four_pole_filter.
package rfpf_pkg;
  localparam int SampleBits = 16;
  localparam int StageBits  = 32;
  localparam int ShiftD     = StageBits - 4 - SampleBits;  // 12
  localparam logic [15:0] CutLow  = 16'd7;
  localparam logic [15:0] CutHigh = 16'd65529;
  localparam logic [16:0] ResOne  = 17'd65536;

  localparam logic [1:0] ModeLp  = 2'd0;
  localparam logic [1:0] ModeHp  = 2'd1;
  localparam logic [1:0] ModeBp  = 2'd2;
  localparam logic [1:0] ModeOff = 2'd3;

  localparam logic [1:0] AddrCutoff = 2'd0;
  localparam logic [1:0] AddrRes    = 2'd1;
  localparam logic [1:0] AddrMode   = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DIV, ST_FB, ST_P1, ST_P2, ST_P3, ST_P4, ST_P5, ST_P6, ST_OUT
  } state_e;

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } div_ctl_t;
endpackage

// ----- rtl/rfpf_div.sv -----
// Restoring radix-2 divider, one quotient bit per cycle (33-bit dividend, 17-bit divisor).
// Depends on rfpf_pkg.
module rfpf_div
  import rfpf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [32:0] dividend_i,
  input  logic [16:0] divisor_i,
  output div_ctl_t    ctl_o,
  output logic [32:0] quot_o
);
  logic [32:0] quot_q, quot_d;
  logic [17:0] rem_q, rem_d;
  logic [16:0] dsr_q, dsr_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [17:0] trial;

  // one shift-subtract step per cycle
  always_comb begin
    quot_d = quot_q; rem_d = rem_q; dsr_d = dsr_q; cnt_d = cnt_q;
    busy_d = busy_q; done_d = 1'b0;
    trial  = {rem_q[16:0], quot_q[32]};
    if (start_i) begin
      quot_d = dividend_i; rem_d = '0; dsr_d = divisor_i;
      cnt_d = 6'd33; busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, dsr_q}) begin
        rem_d  = trial - {1'b0, dsr_q};
        quot_d = {quot_q[31:0], 1'b1};
      end else begin
        rem_d  = trial;
        quot_d = {quot_q[31:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d; rem_q <= rem_d; dsr_q <= dsr_d;
  end

  assign ctl_o  = '{start: start_i, busy: busy_q, done: done_q};
  assign quot_o = quot_q;
endmodule

// ----- rtl/resonant_four_pole_filter.sv -----
// Resonant four-pole filter top level: config port, sequencer, shared multiplier.
// Depends on rfpf_pkg, rfpf_div and resonant_four_pole_filter_macros.svh.
//
// Usage:
//  Input channel: sample_in_i (Q1.15) and envelope_i, valid_i/stall_o.
//  Output channel: sample_out_o (Q1.15), out_valid_o/out_stall_i.
//  Registers cutoff, resonance, filter_mode at byte addresses 0, 4, 8 on the
//  APB port; pready is tied high, reads return the register value.
//  After the accept edge the sequencer starts the divider, waits for its
//  shift-subtract steps for the feedback gain and for its done, then runs one
//  setup step, one pass of the shared 34x33 multiplier per product (five
//  products), one idle slot and the output step.
//  The block takes one item at a time; stall_o is high from accept until
//  the result is written to the output register.
//  If the receiver stalls, the result holds in the output register; the next
//  item is still taken and computed, and waits in the output step until the
//  held result is accepted.
//  Reset clears the four stages and loads the register reset values.
module resonant_four_pole_filter
  import rfpf_pkg::*;
(
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [3:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  input  logic                         valid_i,
  output logic                         stall_o,
  input  logic signed [SampleBits-1:0] sample_in_i,
  input  logic [15:0]                  envelope_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [SampleBits-1:0] sample_out_o
);
  localparam logic signed [StageBits-1:0] SMax = {1'b0, {(StageBits-1){1'b1}}};
  localparam logic signed [StageBits-1:0] SMin = {1'b1, {(StageBits-1){1'b0}}};

  // config registers
  logic [15:0] cutoff_q;
  logic [16:0] res_q;
  logic [1:0]  mode_q;
  logic        wr_en;
  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cutoff_q <= 16'd32768; res_q <= '0; mode_q <= ModeLp;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        AddrCutoff: cutoff_q <= pwdata[15:0];
        AddrRes:    res_q    <= pwdata[16:0];
        AddrMode:   mode_q   <= pwdata[1:0];
        default: ;
      endcase
    end
  end
  always_comb begin
    unique case (paddr[3:2])
      AddrCutoff: prdata = {16'd0, cutoff_q};
      AddrRes:    prdata = {15'd0, res_q};
      AddrMode:   prdata = {30'd0, mode_q};
      default:    prdata = '0;
    endcase
  end

  // coefficient setup
  logic [15:0] cut_c, env_c, env_max;
  logic [16:0] res_c;
  always_comb begin
    cut_c = cutoff_q;
    if (cut_c < CutLow)  cut_c = CutLow;
    if (cut_c > CutHigh) cut_c = CutHigh;
    env_max = CutHigh - cut_c;
    env_c   = (envelope_i > env_max) ? env_max : envelope_i;
    res_c   = (res_q > ResOne) ? ResOne : res_q;
  end

  state_e state_q, state_d;
  logic signed [StageBits-1:0] s1_q, s2_q, s3_q, s4_q, x_q, t_q;
  logic signed [StageBits-1:0] s1_d, s2_d, s3_d, s4_d, x_d, t_d;
  logic [15:0] total_q, total_d;
  logic [16:0] rsv_q, rsv_d;
  logic [31:0] fb_q, fb_d;
  logic signed [SampleBits-1:0] out_q, out_d;
  logic        ov_q, ov_d;
  logic        div_start;
  div_ctl_t    div_ctl;
  logic [32:0] quot;

  rfpf_div u_div (
    .clk_i, .rst_ni, .start_i(div_start),
    .dividend_i({rsv_q, 16'd0}), .divisor_i(17'h10000 - {1'b0, total_q}),
    .ctl_o(div_ctl), .quot_o(quot)
  );

  // shared multiplier: floor(a*b/65536) saturated; a needs 34 bits for the
  // first-stage operand x - s1 + feedback term
  logic signed [StageBits+1:0]  mul_a;
  logic        [31:0]           mul_b;
  logic signed [StageBits+33:0] prod;
  logic signed [StageBits+17:0] psh;
  logic signed [StageBits-1:0]  mul_r;
  assign prod = mul_a * $signed({1'b0, mul_b});
  assign psh  = prod[StageBits+33:16];
  always_comb begin
    if (psh > $signed({{18{SMax[StageBits-1]}}, SMax}))      mul_r = SMax;
    else if (psh < $signed({{18{SMin[StageBits-1]}}, SMin})) mul_r = SMin;
    else mul_r = psh[StageBits-1:0];
  end

  function automatic logic signed [StageBits-1:0] sat1(input logic signed [StageBits:0] v);
    if (v > $signed({SMax[StageBits-1], SMax}))      sat1 = SMax;
    else if (v < $signed({SMin[StageBits-1], SMin})) sat1 = SMin;
    else sat1 = v[StageBits-1:0];
  endfunction

  function automatic logic signed [SampleBits-1:0] to_samp(input logic signed [StageBits:0] v);
    logic signed [StageBits-ShiftD:0] r;
    r = v[StageBits:ShiftD];
    if (r > $signed({{(StageBits-ShiftD-SampleBits+1){1'b0}}, {(SampleBits-1){1'b1}}}))
      to_samp = {1'b0, {(SampleBits-1){1'b1}}};
    else if (r < $signed({{(StageBits-ShiftD-SampleBits+1){1'b1}}, {(SampleBits-1){1'b0}}}))
      to_samp = {1'b1, {(SampleBits-1){1'b0}}};
    else to_samp = r[SampleBits-1:0];
  endfunction

  logic [32:0] fb_sum;
  assign fb_sum = {16'd0, rsv_q} + quot;

  // sequencer
  always_comb begin
    state_d = state_q;
    s1_d = s1_q; s2_d = s2_q; s3_d = s3_q; s4_d = s4_q; x_d = x_q; t_d = t_q;
    total_d = total_q; rsv_d = rsv_q; fb_d = fb_q; out_d = out_q; ov_d = ov_q;
    div_start = 1'b0;
    mul_a = '0; mul_b = '0;
    if (ov_q && !out_stall_i) ov_d = 1'b0;
    unique case (state_q)
      ST_IDLE: if (valid_i) begin
        x_d = StageBits'(sample_in_i) <<< ShiftD;
        total_d = cut_c + env_c; rsv_d = res_c;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        div_start = !div_ctl.busy && !div_ctl.done;
        if (div_ctl.done) state_d = ST_FB;
      end
      ST_FB: begin
        fb_d = fb_sum[32:31] != 2'b00 ? 32'h7FFFFFFF : fb_sum[31:0];
        state_d = ST_P1;
      end
      ST_P1: begin
        mul_a = {{2{s1_q[StageBits-1]}}, s1_q} - {{2{s2_q[StageBits-1]}}, s2_q};
        mul_b = fb_q;
        t_d = mul_r; state_d = ST_P2;
      end
      ST_P2: begin
        mul_a = {{2{x_q[StageBits-1]}}, x_q} - {{2{s1_q[StageBits-1]}}, s1_q}
              + {{2{t_q[StageBits-1]}}, t_q};
        mul_b = {16'd0, total_q};
        s1_d = sat1({s1_q[StageBits-1], s1_q} + {mul_r[StageBits-1], mul_r});
        state_d = ST_P3;
      end
      ST_P3: begin
        mul_a = {{2{s1_q[StageBits-1]}}, s1_q} - {{2{s2_q[StageBits-1]}}, s2_q};
        mul_b = {16'd0, total_q};
        s2_d = sat1({s2_q[StageBits-1], s2_q} + {mul_r[StageBits-1], mul_r});
        state_d = ST_P4;
      end
      ST_P4: begin
        mul_a = {{2{s2_q[StageBits-1]}}, s2_q} - {{2{s3_q[StageBits-1]}}, s3_q};
        mul_b = {16'd0, total_q};
        s3_d = sat1({s3_q[StageBits-1], s3_q} + {mul_r[StageBits-1], mul_r});
        state_d = ST_P5;
      end
      ST_P5: begin
        mul_a = {{2{s3_q[StageBits-1]}}, s3_q} - {{2{s4_q[StageBits-1]}}, s4_q};
        mul_b = {16'd0, total_q};
        s4_d = sat1({s4_q[StageBits-1], s4_q} + {mul_r[StageBits-1], mul_r});
        state_d = ST_P6;
      end
      ST_P6: state_d = ST_OUT;
      // wait here while a held result still occupies the output register
      ST_OUT: if (!ov_q || !out_stall_i) begin
        unique case (mode_q)
          ModeLp: out_d = to_samp({s4_q[StageBits-1], s4_q});
          ModeHp: out_d = to_samp({x_q[StageBits-1], x_q} - {s4_q[StageBits-1], s4_q});
          ModeBp: out_d = to_samp({s1_q[StageBits-1], s1_q} - {s4_q[StageBits-1], s4_q});
          default: out_d = '0;
        endcase
        ov_d = 1'b1; state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // state and stage registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE; ov_q <= 1'b0;
      s1_q <= '0; s2_q <= '0; s3_q <= '0; s4_q <= '0;
    end else begin
      state_q <= state_d; ov_q <= ov_d;
      s1_q <= s1_d; s2_q <= s2_d; s3_q <= s3_d; s4_q <= s4_d;
    end
  end
  always_ff @(posedge clk_i) begin
    x_q <= x_d; t_q <= t_d; total_q <= total_d; rsv_q <= rsv_d;
    fb_q <= fb_d; out_q <= out_d;
  end

  assign stall_o      = (state_q != ST_IDLE);
  assign out_valid_o  = ov_q;
  assign sample_out_o = out_q;

  `include "resonant_four_pole_filter_macros.svh"
  `RFPF_ASSERT_IMP(a_busy_stall, state_q != ST_IDLE, stall_o)
  `RFPF_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(sample_out_o))
  `RFPF_ASSERT_IMP(a_div_only_div, div_ctl.busy, state_q == ST_DIV)
endmodule

// ----- tb/resonant_four_pole_filter_test.sv -----
// Testbench for the resonant four-pole filter: directed and random items with a
// bit-exact filter predictor, register changes over APB, random idling and back pressure.
// Depends on rfpf_pkg and the resonant_four_pole_filter RTL.
module resonant_four_pole_filter_test;
  import rfpf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 1000000;
  localparam int DrainCycles = 60;
  localparam longint StageMax = 64'sd2147483647;
  localparam longint StageMin = -64'sd2147483648;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         psel = 1'b0;
  logic                         penable = 1'b0;
  logic                         pwrite = 1'b0;
  logic [3:0]                   paddr = '0;
  logic [31:0]                  pwdata = '0;
  logic [31:0]                  prdata;
  logic                         pready;
  logic                         valid_i = 1'b0;
  logic                         stall_o;
  logic signed [SampleBits-1:0] sample_in_i = '0;
  logic [15:0]                  envelope_i = '0;
  logic                         out_valid_o;
  logic                         out_stall_i = 1'b0;
  logic signed [SampleBits-1:0] sample_out_o;

  // Predictor copy of the registers and the four stages
  logic [15:0] cut_reg;
  logic [16:0] res_reg;
  logic [1:0]  mode_reg;
  longint      pole_one, pole_two, pole_three, pole_four;

  logic signed [SampleBits-1:0] filtered_q[$];
  int  mismatches = 0;
  int  cycles = 0;
  bit  quiet_idle = 1'b0;   // no gaps on either side
  bit  hold_request = 1'b0; // receiver takes one long hold-off
  int  hold_cycles = 0;

  resonant_four_pole_filter dut (.*);

  // Clock and run limit
  initial begin
    forever begin
      #6 clk_i = ~clk_i;
      if (clk_i) begin
        cycles++;
        if (cycles > CycleLimit) begin
          $display("[FAIL] regression broken");
          $finish;
        end
      end
    end
  end

  function automatic longint clip_stage(longint v);
    if (v > StageMax) return StageMax;
    if (v < StageMin) return StageMin;
    return v;
  endfunction

  // floor(a * b / 65536), saturated to the stage range
  function automatic longint scale_q16(longint a, longint b);
    logic signed [127:0] pa, pb, prod;
    pa = a;
    pb = b;
    prod = (pa * pb) >>> 16;
    if (prod > StageMax) return StageMax;
    if (prod < StageMin) return StageMin;
    return longint'(prod);
  endfunction

  function automatic logic signed [15:0] stage_to_sample(longint v);
    longint r;
    r = v >>> ShiftD;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[15:0];
  endfunction

  // Advance the stages by one item and return the expected output sample
  function automatic logic signed [15:0] filter_step(logic signed [15:0] smp, logic [15:0] env);
    longint x, cut, e, total, res, fb;
    x = longint'(smp) <<< ShiftD;
    cut = cut_reg;
    if (cut < CutLow) cut = CutLow;
    if (cut > CutHigh) cut = CutHigh;
    e = env;
    if (e > CutHigh - cut) e = CutHigh - cut;
    total = cut + e;
    res = res_reg;
    if (res > ResOne) res = ResOne;
    fb = res + (res <<< 16) / (65536 - total);
    if (fb > 64'h7FFFFFFF) fb = 64'h7FFFFFFF;
    pole_one = clip_stage(pole_one + scale_q16(
        x - pole_one + scale_q16(pole_one - pole_two, fb), total));
    pole_two = clip_stage(pole_two + scale_q16(pole_one - pole_two, total));
    pole_three = clip_stage(pole_three + scale_q16(pole_two - pole_three, total));
    pole_four = clip_stage(pole_four + scale_q16(pole_three - pole_four, total));
    case (mode_reg)
      ModeLp: return stage_to_sample(pole_four);
      ModeHp: return stage_to_sample(x - pole_four);
      ModeBp: return stage_to_sample(pole_one - pole_four);
      default: return '0;
    endcase
  endfunction

  // Output check on every accepted result
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (filtered_q.size() == 0) begin
        $error("sample_out: unexpected result %0d", sample_out_o);
        mismatches++;
      end else begin
        if (sample_out_o !== filtered_q[0]) begin
          $error("sample_out: expected %0d, actual %0d", filtered_q[0], sample_out_o);
          mismatches++;
        end
        void'(filtered_q.pop_front());
      end
    end
  end

  // Receiver: random stall before each result, one long counted hold-off on request
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall_i <= 1'b1;
        hold_cycles = 0;
        while (hold_cycles < 400) begin
          @(posedge clk_i);
          hold_cycles++;
        end
      end else begin
        n = quiet_idle ? 0 : $urandom_range(0, 16);
        if (n > 0) begin
          out_stall_i <= 1'b1;
          repeat (n) @(posedge clk_i);
        end
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  // Send one item after a random gap; predict when it is accepted
  task automatic send_item(logic signed [15:0] smp, logic [15:0] env);
    int gap;
    gap = quiet_idle ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    valid_i <= 1'b1;
    sample_in_i <= smp;
    envelope_i <= env;
    @(posedge clk_i);
    while (stall_o) @(posedge clk_i);
    filtered_q.push_back(filter_step(smp, env));
  endtask

  task automatic drain();
    valid_i <= 1'b0;
    while (filtered_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Register write, only called while the block is idle; the bus idles before the copy is updated
  task automatic reg_write(logic [1:0] idx, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
    case (idx)
      AddrCutoff: cut_reg = value[15:0];
      AddrRes: res_reg = value[16:0];
      default: mode_reg = value[1:0];
    endcase
  endtask

  task automatic set_filter(logic [15:0] cut, logic [16:0] res, logic [1:0] mode);
    reg_write(AddrCutoff, 32'(cut));
    reg_write(AddrRes, 32'(res));
    reg_write(AddrMode, 32'(mode));
  endtask

  function automatic logic signed [15:0] rand_sample();
    case ($urandom_range(0, 5))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'($signed($urandom_range(0, 255)) - 128);
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic logic [15:0] rand_envelope();
    case ($urandom_range(0, 4))
      0: return 16'hFFFF;
      1: return '0;
      2: return 16'($urandom_range(0, 2000));
      default: return 16'($urandom());
    endcase
  endfunction

  // Reset values of the registers drive the first items
  task automatic test_reset_values();
    send_item(16'sh7FFF, 16'd0);
    send_item(16'sh7FFF, 16'd100);
    send_item(16'sh8000, 16'd0);
    drain();
  endtask

  // Register extremes, every mode, input extremes and clamps
  task automatic test_directed_cases();
    // cutoff below range, resonance above one, low-pass
    set_filter(16'd0, 17'h1FFFF, ModeLp);
    send_item(16'sh7FFF, 16'd0);
    send_item(16'sh8000, 16'hFFFF);
    drain();
    // cutoff above range, envelope clamp, high-pass
    set_filter(16'hFFFF, 17'd65536, ModeHp);
    send_item(16'sh8000, 16'hFFFF);
    send_item(16'sh7FFF, 16'd5);
    send_item(16'sh0000, 16'd0);
    drain();
    // band-pass at the range edges with strong feedback
    set_filter(16'd7, 17'd65536, ModeBp);
    send_item(16'sh7FFF, 16'hFFFF);
    send_item(16'sh8000, 16'hFFFF);
    send_item(16'sh7FFF, 16'hFFFF);
    send_item(16'sh0001, 16'd0);
    drain();
    // silent mode still advances the stages
    set_filter(16'd65529, 17'd0, ModeOff);
    send_item(16'sh7FFF, 16'd0);
    send_item(16'sh8000, 16'd1);
    drain();
    set_filter(16'd40000, 17'd60000, ModeLp);
    send_item(16'shFFFF, 16'd30000);
    send_item(16'sh5555, 16'hAAAA);
    send_item(16'shAAAA, 16'h5555);
    drain();
  endtask

  // Long receiver hold-off while items keep coming
  task automatic test_back_pressure();
    set_filter(16'd20000, 17'd30000, ModeHp);
    hold_request = 1'b1;
    quiet_idle = 1'b1;
    repeat (8) send_item(rand_sample(), rand_envelope());
    quiet_idle = 1'b0;
    drain();
  endtask

  // Random items over several register settings, some without idling
  task automatic test_random_items();
    logic [15:0] cut;
    logic [16:0] res;
    for (int phase = 0; phase < 12; phase++) begin
      case ($urandom_range(0, 3))
        0: cut = 16'($urandom_range(0, 10));
        1: cut = 16'($urandom_range(65520, 65535));
        default: cut = 16'($urandom());
      endcase
      case ($urandom_range(0, 3))
        0: res = '0;
        1: res = 17'($urandom_range(65530, 131071));
        default: res = 17'($urandom_range(0, 65536));
      endcase
      set_filter(cut, res, 2'($urandom_range(0, 3)));
      quiet_idle = (phase % 4 == 3);
      repeat (100) send_item(rand_sample(), rand_envelope());
      quiet_idle = 1'b0;
      drain();
    end
  endtask

  initial begin
    cut_reg = 16'd32768;
    res_reg = '0;
    mode_reg = ModeLp;
    pole_one = 0;
    pole_two = 0;
    pole_three = 0;
    pole_four = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_values();
    test_directed_cases();
    test_back_pressure();
    test_random_items();
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
